/* rtl/eadet_pkg.sv */
// Shared types and constants for the edge anchor detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package eadet_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAG_BINS  = 2048;

   localparam int MAG_W   = 11;
   localparam int CNT_W   = 21;
   localparam int POS_W   = 10;
   localparam int CFG_W   = 11;
   localparam int STEP_W  = 5;
   localparam int PH_W    = 4;
   localparam int BIN_W   = 12;   // wide enough for the largest bin count parameter
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;
   localparam int REQ_DW  = 40;
   localparam int RSP_DW  = 48;

   localparam logic [1:0] ACT_PIXEL = 2'd0;
   localparam logic [1:0] ACT_FRAME = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic KIND_DECISION = 1'b0;
   localparam logic KIND_BIN      = 1'b1;

   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_MAG_THRESH   = 3'd2;
   localparam logic [2:0] REG_ANCHOR_MARG  = 3'd3;
   localparam logic [2:0] REG_SCAN_STEP    = 3'd4;

   localparam logic [CNT_W-1:0] CNT_SAT = '1;
   localparam logic [MAG_W-1:0] MAG_SAT = '1;

   typedef struct packed {
      logic [CFG_W-1:0]  frame_width;
      logic [CFG_W-1:0]  frame_height;
      logic [CFG_W-1:0]  magnitude_threshold;
      logic [CFG_W-1:0]  anchor_margin;
      logic [STEP_W-1:0] scan_step;
   } cfg_type;

   typedef struct packed {
      logic             rd_en;
      logic [BIN_W-1:0] rd_bin;
      logic             wr_en;
      logic [BIN_W-1:0] wr_bin;
      logic [CNT_W-1:0] wr_val;
      logic             clr_start;
   } hist_ctl_type;

endpackage

`default_nettype wire

/* rtl/eadet_csr.sv */
// Configuration register file behind the APB-style port.
// Depends on eadet_pkg for the register codes and the config struct.
`timescale 1ns / 1ps
`default_nettype none

module eadet_csr
   import eadet_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width         <= CFG_W'(640);
         cfg_ff.frame_height        <= CFG_W'(480);
         cfg_ff.magnitude_threshold <= CFG_W'(36);
         cfg_ff.anchor_margin       <= CFG_W'(8);
         cfg_ff.scan_step           <= STEP_W'(1);
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_FRAME_WIDTH:  cfg_ff.frame_width         <= csr_pwdata[CFG_W-1:0];
            REG_FRAME_HEIGHT: cfg_ff.frame_height        <= csr_pwdata[CFG_W-1:0];
            REG_MAG_THRESH:   cfg_ff.magnitude_threshold <= csr_pwdata[CFG_W-1:0];
            REG_ANCHOR_MARG:  cfg_ff.anchor_margin       <= csr_pwdata[CFG_W-1:0];
            REG_SCAN_STEP:    cfg_ff.scan_step           <= csr_pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DW'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DW'(cfg_ff.frame_height);
         REG_MAG_THRESH:   csr_prdata = CSR_DW'(cfg_ff.magnitude_threshold);
         REG_ANCHOR_MARG:  csr_prdata = CSR_DW'(cfg_ff.anchor_margin);
         REG_SCAN_STEP:    csr_prdata = CSR_DW'(cfg_ff.scan_step);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/eadet_line.sv */
// Two line stores (one per row parity) of {direction, magnitude}.
// Depends on eadet_pkg; cleared by a sweep after reset.
`timescale 1ns / 1ps
`default_nettype none

module eadet_line
   import eadet_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_WIDTH
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic                     par,
   input  wire logic [MAG_W:0]           wdata,
   output logic      [MAG_W:0]           rd0,
   output logic      [MAG_W:0]           rd1,
   output logic                          busy
);

   localparam int LW = $clog2(DEPTH);
   localparam logic [LW-1:0] LAST = LW'(DEPTH - 1);

   logic [MAG_W:0] mem0 [DEPTH];
   logic [MAG_W:0] mem1 [DEPTH];
   logic [MAG_W:0] rd0_ff, rd1_ff;
   logic [LW-1:0]  sweep_ff;
   logic           sweeping_ff;

   assign busy = sweeping_ff;
   assign rd0  = rd0_ff;
   assign rd1  = rd1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweeping_ff <= 1'b1;
         sweep_ff    <= '0;
      end else if (sweeping_ff) begin
         sweep_ff <= sweep_ff + 1'b1;
         if (sweep_ff == LAST) sweeping_ff <= 1'b0;
      end
   end

   // read before write: the old row comes out at the address being replaced
   always_ff @(posedge clock) begin
      if (sweeping_ff) begin
         mem0[sweep_ff] <= '0;
         mem1[sweep_ff] <= '0;
      end else if (en) begin
         if (par) mem1[addr] <= wdata;
         else     mem0[addr] <= wdata;
         rd0_ff <= mem0[addr];
         rd1_ff <= mem1[addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/eadet_hist.sv */
// Magnitude histogram memory with one read and one write port and a clear sweep.
// Depends on eadet_pkg for the control struct and counter width.
`timescale 1ns / 1ps
`default_nettype none

module eadet_hist
   import eadet_pkg::*;
#(
   parameter int MAG_BINS = DEF_MAG_BINS
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire hist_ctl_type ctl,
   output logic [CNT_W-1:0]  rd_data,
   output logic              busy
);

   localparam int HW = $clog2(MAG_BINS);
   localparam logic [HW-1:0] LAST = HW'(MAG_BINS - 1);

   logic [CNT_W-1:0] mem [MAG_BINS];
   logic [CNT_W-1:0] rd_ff;
   logic [HW-1:0]    sweep_ff;
   logic             sweeping_ff;

   assign busy    = sweeping_ff;
   assign rd_data = rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweeping_ff <= 1'b1;
         sweep_ff    <= '0;
      end else if (sweeping_ff) begin
         sweep_ff <= sweep_ff + 1'b1;
         if (sweep_ff == LAST) sweeping_ff <= 1'b0;
      end else if (ctl.clr_start) begin
         sweeping_ff <= 1'b1;
         sweep_ff    <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (sweeping_ff) mem[sweep_ff] <= '0;
      else if (ctl.wr_en) mem[ctl.wr_bin[HW-1:0]] <= ctl.wr_val;
      if (ctl.rd_en) rd_ff <= mem[ctl.rd_bin[HW-1:0]];
   end

endmodule

`default_nettype wire

/* rtl/edge_anchor_detector_core.sv */
// Edge anchor detector: takes one gradient word per clock when not stalled, decides each
// interior pixel one row and one column behind the input and answers histogram bin reads in
// stream order. The input register takes the line-store read, then window, decision and
// histogram read feed the result register; a new word is taken every cycle unless the
// output stalls or a sweep or clear is pending. After reset no word is taken while line
// stores and histogram are swept to zero; a start-of-frame word drains the pipeline and
// then blocks input while the histogram is cleared.
// Depends on eadet_pkg, eadet_csr, eadet_line and eadet_hist.
`timescale 1ns / 1ps
`default_nettype none

module edge_anchor_detector_core
   import eadet_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAG_BINS  = DEF_MAG_BINS
)(
   input  wire logic              clock,
   input  wire logic              reset,
   // tdata: grad_x[10:0], grad_y[21:11], bin_index[32:22], zero fill
   input  wire logic [REQ_DW-1:0] req_tdata,
   // tuser: action[1:0]
   input  wire logic [1:0]        req_tuser,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // tdata: is_anchor[0], center_row[10:1], center_col[20:11], bin_count[41:21], zero fill
   output logic      [RSP_DW-1:0] rsp_tdata,
   // tuser: kind[0]
   output logic                   rsp_tuser,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   localparam int EFF = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int LW  = $clog2(EFF);
   localparam logic [CFG_W-1:0] W_TOP   = CFG_W'(EFF);
   localparam logic [CFG_W-1:0] H_TOP   = CFG_W'(1024);
   localparam logic [12:0]      BIN_TOP = 13'(MAG_BINS - 1);
   localparam logic [12:0]      BIN_NUM = 13'(MAG_BINS);

   cfg_type      cfg;
   hist_ctl_type hctl;
   logic         line_busy, hist_busy;
   logic [MAG_W:0]   rd0, rd1;
   logic [CNT_W-1:0] hist_rd;

   eadet_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   // ---------------- input stage ----------------
   logic [MAG_W-1:0] gx, gy, ax, ay, mag, idx;
   logic [MAG_W:0]   sum;
   logic             dir;
   logic [CFG_W-1:0] w, h;
   logic [STEP_W-1:0] step;
   logic [POS_W-1:0] col_ff, row_ff, c, r;
   logic [PH_W-1:0]  cph_ff, rph_ff, cph, rph;
   logic [PH_W:0]    cph_nx, rph_nx;
   logic             c_last, r_last, on_grid, decide;
   logic             acc, pix_acc, frm_acc, rd_acc;

   assign gx  = req_tdata[10:0];
   assign gy  = req_tdata[21:11];
   assign idx = req_tdata[32:22];
   assign ax  = gx[MAG_W-1] ? (~gx + 1'b1) : gx;
   assign ay  = gy[MAG_W-1] ? (~gy + 1'b1) : gy;
   assign sum = {1'b0, ax} + {1'b0, ay};
   assign mag = sum[MAG_W] ? MAG_SAT : sum[MAG_W-1:0];
   assign dir = (ax >= ay);

   always_comb begin
      if (cfg.frame_width < CFG_W'(3))   w = CFG_W'(3);
      else if (cfg.frame_width > W_TOP)  w = W_TOP;
      else                               w = cfg.frame_width;
      if (cfg.frame_height < CFG_W'(3))  h = CFG_W'(3);
      else if (cfg.frame_height > H_TOP) h = H_TOP;
      else                               h = cfg.frame_height;
      if (cfg.scan_step == '0)                   step = STEP_W'(1);
      else if (cfg.scan_step > STEP_W'(16))      step = STEP_W'(16);
      else                                       step = cfg.scan_step;
   end

   // counts beyond a newly shrunk frame wrap at once
   assign c   = ({1'b0, col_ff} >= w) ? '0 : col_ff;
   assign cph = ({1'b0, col_ff} >= w) ? '0 : cph_ff;
   assign r   = ({1'b0, row_ff} >= h) ? '0 : row_ff;
   assign rph = ({1'b0, row_ff} >= h) ? '0 : rph_ff;

   assign c_last = ({1'b0, c} + 1'b1) >= w;
   assign r_last = ({1'b0, r} + 1'b1) >= h;
   assign cph_nx = ({1'b0, cph} + 1'b1 >= step) ? '0 : {1'b0, cph} + 1'b1;
   assign rph_nx = ({1'b0, rph} + 1'b1 >= step) ? '0 : {1'b0, rph} + 1'b1;

   // grid test uses the phase of the center, one behind
   assign on_grid = (rph == PH_W'(1)) || (rph == '0 && step == STEP_W'(1)) ||
                    (cph == PH_W'(1)) || (cph == '0 && step == STEP_W'(1));
   assign decide  = (r >= POS_W'(2)) && (c >= POS_W'(2));

   // ---------------- stage 1: window and decision ----------------
   logic             s1_vld_ff, s1_pix_ff, s1_dec_ff, s1_rd_ff, s1_par_ff, s1_grid_ff;
   logic [MAG_W:0]   s1_cur_ff;
   logic [POS_W-1:0] s1_row_ff, s1_col_ff;
   logic [MAG_W-1:0] s1_idx_ff;
   logic [MAG_W:0]   win0_ff, win1_ff, win2_ff, win3_ff, mid, old;
   logic [MAG_W-1:0] cm, n1, n2;
   logic             tested, anchor, inc, s1_adv, s2_load, s2_free;
   logic [12:0]      bin13;
   logic             clr_pend_ff;

   assign mid = s1_par_ff ? rd0 : rd1;
   assign old = s1_par_ff ? rd1 : rd0;
   assign cm  = win0_ff[MAG_W-1:0];
   assign n1  = win0_ff[MAG_W] ? win2_ff[MAG_W-1:0] : win1_ff[MAG_W-1:0];
   assign n2  = win0_ff[MAG_W] ? win3_ff[MAG_W-1:0] : mid[MAG_W-1:0];
   assign tested = s1_grid_ff && (cm >= cfg.magnitude_threshold);
   assign anchor = tested &&
                   ({1'b0, cm} >= {1'b0, n1} + {1'b0, cfg.anchor_margin}) &&
                   ({1'b0, cm} >= {1'b0, n2} + {1'b0, cfg.anchor_margin});
   assign inc   = tested && (cm != '0);
   assign bin13 = ({2'b0, cm} > BIN_TOP) ? BIN_TOP : {2'b0, cm};

   logic             s2_vld_ff, s2_kind_ff, s2_anchor_ff, s2_inc_ff, s2_rd_ff, s2_inr_ff;
   logic [POS_W-1:0] s2_row_ff, s2_col_ff;
   logic [BIN_W-1:0] s2_bin_ff;

   assign s2_free = !s2_vld_ff || rsp_tready;
   assign s1_adv  = s1_vld_ff && (!(s1_dec_ff || s1_rd_ff) || s2_free);
   assign s2_load = s1_adv && (s1_dec_ff || s1_rd_ff);

   assign req_tready = !line_busy && !hist_busy && !clr_pend_ff && (!s1_vld_ff || s1_adv);
   assign acc     = req_tvalid && req_tready;
   assign pix_acc = acc && (req_tuser == ACT_PIXEL);
   assign frm_acc = acc && (req_tuser == ACT_FRAME);
   assign rd_acc  = acc && (req_tuser == ACT_READ);

   eadet_line #(.DEPTH(EFF)) u_line (
      .clock, .reset, .en(pix_acc), .addr(c[LW-1:0]), .par(r[0]),
      .wdata({dir, mag}), .rd0, .rd1, .busy(line_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cph_ff <= '0;
         rph_ff <= '0;
      end else if (frm_acc) begin
         col_ff <= '0;
         row_ff <= '0;
         cph_ff <= '0;
         rph_ff <= '0;
      end else if (pix_acc) begin
         if (c_last) begin
            col_ff <= '0;
            cph_ff <= '0;
            if (r_last) begin
               row_ff <= '0;
               rph_ff <= '0;
            end else begin
               row_ff <= r + 1'b1;
               rph_ff <= rph_nx[PH_W-1:0];
            end
         end else begin
            col_ff <= c + 1'b1;
            cph_ff <= cph_nx[PH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (pix_acc || rd_acc) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_acc || rd_acc) begin
         s1_pix_ff  <= pix_acc;
         s1_dec_ff  <= pix_acc && decide;
         s1_rd_ff   <= rd_acc;
         s1_par_ff  <= r[0];
         s1_grid_ff <= on_grid;
         s1_cur_ff  <= {dir, mag};
         s1_row_ff  <= r - 1'b1;
         s1_col_ff  <= c - 1'b1;
         s1_idx_ff  <= idx;
      end
   end

   // frame start wins over a shift in the same cycle
   always_ff @(posedge clock) begin
      if (reset || frm_acc) begin
         win0_ff <= '0;
         win1_ff <= '0;
         win2_ff <= '0;
         win3_ff <= '0;
      end else if (s1_adv && s1_pix_ff) begin
         win1_ff <= win0_ff;
         win0_ff <= mid;
         win2_ff <= old;
         win3_ff <= s1_cur_ff;
      end
   end

   // ---------------- stage 2: result register and histogram update ----------------
   logic             wr_vld_ff;
   logic [BIN_W-1:0] wr_bin_ff;
   logic [CNT_W-1:0] wr_val_ff, cur_cnt, inc_cnt;
   logic             clr_start;

   assign cur_cnt = (wr_vld_ff && wr_bin_ff == s2_bin_ff) ? wr_val_ff : hist_rd;
   assign inc_cnt = (cur_cnt == CNT_SAT) ? cur_cnt : cur_cnt + 1'b1;
   assign clr_start = clr_pend_ff && !s1_vld_ff && !s2_vld_ff;

   always_comb begin
      hctl.rd_en     = s2_load;
      hctl.rd_bin    = s1_dec_ff ? bin13[BIN_W-1:0] : BIN_W'(s1_idx_ff);
      hctl.wr_en     = s2_vld_ff && s2_inc_ff && rsp_tready;
      hctl.wr_bin    = s2_bin_ff;
      hctl.wr_val    = inc_cnt;
      hctl.clr_start = clr_start;
   end

   eadet_hist #(.MAG_BINS(MAG_BINS)) u_hist (
      .clock, .reset, .ctl(hctl), .rd_data(hist_rd), .busy(hist_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff   <= 1'b0;
         clr_pend_ff <= 1'b0;
         wr_vld_ff   <= 1'b0;
      end else begin
         if (s2_load)         s2_vld_ff <= 1'b1;
         else if (rsp_tready) s2_vld_ff <= 1'b0;
         if (frm_acc)        clr_pend_ff <= 1'b1;
         else if (clr_start) clr_pend_ff <= 1'b0;
         if (clr_start)       wr_vld_ff <= 1'b0;
         else if (hctl.wr_en) wr_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (hctl.wr_en) begin
         wr_bin_ff <= hctl.wr_bin;
         wr_val_ff <= hctl.wr_val;
      end
      if (s2_load) begin
         s2_kind_ff   <= s1_dec_ff ? KIND_DECISION : KIND_BIN;
         s2_anchor_ff <= s1_dec_ff && anchor;
         s2_row_ff    <= s1_dec_ff ? s1_row_ff : '0;
         s2_col_ff    <= s1_dec_ff ? s1_col_ff : '0;
         s2_inc_ff    <= s1_dec_ff && inc;
         s2_rd_ff     <= s1_rd_ff;
         s2_inr_ff    <= ({2'b0, s1_idx_ff} < BIN_NUM);
         s2_bin_ff    <= hctl.rd_bin;
      end
   end

   assign rsp_tvalid = s2_vld_ff;
   assign rsp_tuser  = s2_kind_ff;
   assign rsp_tdata  = {6'b0, (s2_rd_ff && s2_inr_ff) ? cur_cnt : '0,
                        s2_col_ff, s2_row_ff, s2_anchor_ff};

endmodule

`default_nettype wire
